FILE: rtl/cdate_pkg.sv
// shared types, constants and calendar functions for the calendar date counter
// no dependencies
`default_nettype none

package cdate_pkg;

    // operation codes
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_INC = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;
    localparam logic [1:0] OP_SUB = 2'd3;

    // error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_BAD_MONTH = 2'd1;
    localparam logic [1:0] ERR_BAD_YEAR  = 2'd2;
    localparam logic [1:0] ERR_BAD_DAY   = 2'd3;

    // date limits and reset values
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;
    localparam logic [4:0]  FEB_LEAP    = 5'd29;
    localparam logic [11:0] YEAR_MIN    = 12'd1900;
    localparam logic [11:0] YEAR_MAX    = 12'd2100;
    localparam logic [11:0] YEAR_RESET  = 12'd1900;
    localparam logic [11:0] YEAR_STEP_DOWN = 12'd4;

    // default width of the add-days counter
    localparam int COUNT_BITS_DEF = 16;

    // month lengths, index 0 unused
    localparam logic [4:0] MONTH_DAYS [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // multiples of 100 and 400 that fit in 12 bits
    localparam int CENTURY_COUNT = 4095 / 100;
    localparam int QUAD_COUNT    = 4095 / 400;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [11:0] new_year;
        logic [15:0] day_count;
    } cdate_in_t;

    typedef struct packed {
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [11:0] year_out;
        logic [1:0]  error_code;
    } cdate_out_t;

    // controller to datapath
    typedef struct packed {
        logic load_cmd;
        logic exec;
        logic step_add;
        logic load_out;
    } cdate_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_add;
        logic cnt_zero;
        logic out_free;
    } cdate_status_t;

    // gregorian leap rule, parallel compare against century marks
    function automatic logic is_leap(input logic [11:0] y);
        logic c100;
        logic c400;
        c100 = 1'b0;
        c400 = 1'b0;
        for (int k = 0; k <= CENTURY_COUNT; k++) begin
            if (y == 12'(k * 100)) c100 = 1'b1;
        end
        for (int k = 0; k <= QUAD_COUNT; k++) begin
            if (y == 12'(k * 400)) c400 = 1'b1;
        end
        return (y[1:0] == 2'b00) && (!c100 || c400);
    endfunction

    // days in month, 31 for a month code out of range
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [11:0] y);
        logic [4:0] len;
        if (m < MONTH_FIRST || m > MONTH_LAST) begin
            len = MONTH_DAYS[1];
        end else if (m == 4'd2 && is_leap(y)) begin
            len = FEB_LEAP;
        end else begin
            len = MONTH_DAYS[m];
        end
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cdate_dpath.sv
// datapath: date registers, add-days counter, command latch and result register
// depends on cdate_pkg
`default_nettype none

module cdate_dpath import cdate_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire cdate_in_t     s_data,
    output cdate_out_t         m_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire cdate_cmd_t    cmd,
    output cdate_status_t      status
);

    // latched request
    cdate_in_t req_reg;

    // date state
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  err_reg, err_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    // result register
    logic       m_valid_reg, m_valid_next;
    cdate_out_t m_data_reg;

    // one-day advance
    logic [4:0]  len_cur;
    logic [3:0]  inc_month;
    logic [4:0]  inc_day;
    logic [11:0] inc_year;

    // set checks
    logic       m_ok, y_ok, d_ok;
    logic [4:0] len_set;
    logic [31:0] count_ext;

    assign count_ext = 32'(req_reg.day_count);

    always_comb begin
        len_cur   = month_length(month_reg, year_reg);
        inc_month = month_reg;
        inc_day   = day_reg;
        inc_year  = year_reg;
        if (day_reg < len_cur) begin
            inc_day = day_reg + 5'd1;
        end else if (month_reg < MONTH_LAST) begin
            inc_month = month_reg + 4'd1;
            inc_day   = DAY_FIRST;
        end else begin
            inc_year  = year_reg + 12'd1;
            inc_month = MONTH_FIRST;
            inc_day   = DAY_FIRST;
        end
    end

    always_comb begin
        m_ok    = (req_reg.new_month >= MONTH_FIRST) && (req_reg.new_month <= MONTH_LAST);
        y_ok    = (req_reg.new_year >= YEAR_MIN) && (req_reg.new_year <= YEAR_MAX);
        len_set = month_length(req_reg.new_month, req_reg.new_year);
        d_ok    = (req_reg.new_day >= DAY_FIRST) && (req_reg.new_day <= len_set);
    end

    // next state of the date
    always_comb begin
        month_next = month_reg;
        day_next   = day_reg;
        year_next  = year_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        if (cmd.exec) begin
            err_next = ERR_OK;
            case (req_reg.operation)
                OP_SET: begin
                    if (!m_ok) begin
                        err_next = ERR_BAD_MONTH;
                    end else begin
                        month_next = req_reg.new_month;
                        if (!y_ok) begin
                            err_next = ERR_BAD_YEAR;
                        end else begin
                            year_next = req_reg.new_year;
                            if (!d_ok) begin
                                err_next = ERR_BAD_DAY;
                            end else begin
                                day_next = req_reg.new_day;
                            end
                        end
                    end
                end
                OP_INC: begin
                    month_next = inc_month;
                    day_next   = inc_day;
                    year_next  = inc_year;
                end
                OP_ADD: begin
                    cnt_next = count_ext[COUNT_BITS-1:0];
                end
                default: begin
                    year_next = year_reg - YEAR_STEP_DOWN;
                end
            endcase
        end else if (cmd.step_add) begin
            month_next = inc_month;
            day_next   = inc_day;
            year_next  = inc_year;
            cnt_next   = cnt_reg - COUNT_BITS'(1);
        end
    end

    // control registers and date
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            month_reg   <= MONTH_FIRST;
            day_reg     <= DAY_FIRST;
            year_reg    <= YEAR_RESET;
            err_reg     <= ERR_OK;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            month_reg   <= month_next;
            day_reg     <= day_next;
            year_reg    <= year_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_cmd) begin
            req_reg <= s_data;
        end
        if (cmd.load_out) begin
            m_data_reg.month_out  <= month_reg;
            m_data_reg.day_out    <= day_reg;
            m_data_reg.year_out   <= year_reg;
            m_data_reg.error_code <= err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.is_add   = (req_reg.operation == OP_ADD);
    assign status.cnt_zero = (cnt_reg == '0);
    assign status.out_free = !m_valid_reg || m_ready;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    // the add loop is finished whenever a result is loaded
    a_cnt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (cnt_reg == '0))
        else $error("result loaded with days still pending");

    // month stays a real month
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= MONTH_FIRST) && (month_reg <= MONTH_LAST))
        else $error("month register out of range");

    // only a set request reports an error
    a_err_set_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && req_reg.operation != OP_SET) |=> (err_reg == ERR_OK))
        else $error("error code on a non-set request");

endmodule

`default_nettype wire

FILE: rtl/cdate_ctrl.sv
// controller: sequences request intake, execution, the add-days loop and result load
// depends on cdate_pkg
`default_nettype none

module cdate_ctrl import cdate_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cdate_status_t status,
    output cdate_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_POST = 2'd3;

    logic [1:0] state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.load_cmd = 1'b0;
        cmd.exec     = 1'b0;
        cmd.step_add = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.is_add ? ST_ADD : ST_POST;
            end
            ST_ADD: begin
                if (status.cnt_zero) begin
                    state_next = ST_POST;
                end else begin
                    cmd.step_add = 1'b1;
                end
            end
            ST_POST: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a request leads to execution on the next cycle
    a_exec_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_cmd |=> cmd.exec)
        else $error("request accepted without execution");

    // loop steps only while days remain
    a_step_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step_add |-> !status.cnt_zero)
        else $error("add step with zero count");

endmodule

`default_nettype wire

FILE: rtl/calendar_date_counter_core.sv
// calendar date counter: set, increment, add-days and minus-four-years on a gregorian date
// the add loop advances one day per cycle; a new request is accepted only after the previous
// result has been loaded into the output register, where a finished result waits until taken.
// synchronous active-low reset restores January 1, 1900 and an empty output.
// depends on cdate_pkg, cdate_ctrl, cdate_dpath
`default_nettype none

module calendar_date_counter_core import cdate_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire cdate_in_t  s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output cdate_out_t      m_data
);

    cdate_cmd_t    cmd;
    cdate_status_t status;

    // sequencing
    cdate_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // date state and result register
    cdate_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for calendar_date_counter_core: directed and random date commands
// with random idling on both channels. depends on cdate_pkg and calendar_date_counter_core
module tb_top import cdate_pkg::*; ();

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 950;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    cdate_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    cdate_out_t m_data;

    // date as the block should hold it
    logic [3:0]  cal_month = MONTH_FIRST;
    logic [4:0]  cal_day   = DAY_FIRST;
    logic [11:0] cal_year  = YEAR_RESET;

    cdate_out_t expected_dates[$];

    int error_count    = 0;
    int request_count  = 0;
    int result_count   = 0;
    int rejected_sets  = 0;
    int days_added     = 0;
    int cycle_count    = 0;
    int stall_left     = 0;
    int big_adds_left  = 3;
    bit no_idle        = 1'b0;

    calendar_date_counter_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // gregorian leap rule on the wrapped 12-bit year
    function automatic bit leap_year(input logic [11:0] y);
        int unsigned yi;
        yi = 32'(y);
        return (yi % 400 == 0) || ((yi % 100 != 0) && (yi % 4 == 0));
    endfunction

    // month length, 31 for a month out of range
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [11:0] y);
        case (m)
            4'd2:                     return leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
            default:                  return 5'd31;
        endcase
    endfunction

    // one day forward; a day at or past the month end rolls over
    function automatic void advance_day();
        if (cal_day < days_in_month(cal_month, cal_year)) begin
            cal_day = cal_day + 5'd1;
        end else if (cal_month < MONTH_LAST) begin
            cal_month = cal_month + 4'd1;
            cal_day   = DAY_FIRST;
        end else begin
            cal_year  = cal_year + 12'd1;
            cal_month = MONTH_FIRST;
            cal_day   = DAY_FIRST;
        end
    endfunction

    // set writes month, then year, then day, stopping at the first bad field
    function automatic logic [1:0] apply_set(input logic [3:0] m, input logic [4:0] d,
                                             input logic [11:0] y);
        if (m < MONTH_FIRST || m > MONTH_LAST) return ERR_BAD_MONTH;
        cal_month = m;
        if (y < YEAR_MIN || y > YEAR_MAX) return ERR_BAD_YEAR;
        cal_year = y;
        if (d < DAY_FIRST || d > days_in_month(m, y)) return ERR_BAD_DAY;
        cal_day = d;
        return ERR_OK;
    endfunction

    // date and error code after one request
    function automatic cdate_out_t apply_request(input cdate_in_t req);
        cdate_out_t  res;
        logic [1:0]  err;
        int unsigned left;
        err = ERR_OK;
        case (req.operation)
            OP_SET: err = apply_set(req.new_month, req.new_day, req.new_year);
            OP_INC: advance_day();
            OP_ADD: begin
                left = 32'(req.day_count);
                while (left != 0) begin
                    advance_day();
                    left--;
                end
            end
            default: cal_year = cal_year - YEAR_STEP_DOWN;
        endcase
        res.month_out  = cal_month;
        res.day_out    = cal_day;
        res.year_out   = cal_year;
        res.error_code = err;
        return res;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request with random content in the fields the operation ignores
    function automatic cdate_in_t noise_request(input logic [1:0] op);
        cdate_in_t req;
        req.operation = op;
        req.new_month = 4'($urandom);
        req.new_day   = 5'($urandom);
        req.new_year  = 12'($urandom);
        req.day_count = 16'($urandom);
        return req;
    endfunction

    function automatic cdate_in_t set_request(input logic [3:0] m, input logic [4:0] d,
                                              input logic [11:0] y);
        cdate_in_t req;
        req = noise_request(OP_SET);
        req.new_month = m;
        req.new_day   = d;
        req.new_year  = y;
        return req;
    endfunction

    function automatic cdate_in_t add_request(input logic [15:0] count);
        cdate_in_t req;
        req = noise_request(OP_ADD);
        req.day_count = count;
        return req;
    endfunction

    // random mix: sets (mostly valid), increments, short or rare full-range adds, minus-four
    function automatic cdate_in_t random_request();
        cdate_in_t  req;
        int         r;
        logic [3:0] m;
        logic [11:0] y;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            req = noise_request(OP_SET);
            if ($urandom_range(0, 3) != 0) begin
                m = 4'($urandom_range(1, 12));
                y = 12'($urandom_range(1900, 2100));
                req.new_month = m;
                req.new_year  = y;
                req.new_day   = 5'($urandom_range(1, 32'(days_in_month(m, y))));
            end
        end else if (r < 50) begin
            req = noise_request(OP_INC);
        end else if (r < 80) begin
            req = noise_request(OP_ADD);
            r = $urandom_range(0, 99);
            if (big_adds_left != 0 && $urandom_range(0, 199) == 0) begin
                big_adds_left--;
                req.day_count = 16'($urandom_range(0, 65535));
            end else if (r < 70) begin
                req.day_count = 16'($urandom_range(0, 40));
            end else if (r < 95) begin
                req.day_count = 16'($urandom_range(41, 1000));
            end else begin
                req.day_count = 16'($urandom_range(1001, 5000));
            end
        end else begin
            req = noise_request(OP_SUB);
        end
        return req;
    endfunction

    // one request: optional idle, then hold valid until accepted
    task automatic send_request(input cdate_in_t req);
        int         gap;
        cdate_out_t res;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        res = apply_request(req);
        expected_dates.push_back(res);
        request_count++;
        if (req.operation == OP_SET && res.error_code != ERR_OK) rejected_sets++;
        if (req.operation == OP_ADD) days_added += 32'(req.day_count);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, result_count, got, want);
        error_count++;
    endtask

    task automatic check_result(input cdate_out_t got);
        cdate_out_t want;
        if (expected_dates.size() == 0) begin
            report_mismatch("result with no request pending", 32'(got), 0);
            return;
        end
        want = expected_dates.pop_front();
        if (got.month_out !== want.month_out)
            report_mismatch("month_out", 32'(got.month_out), 32'(want.month_out));
        if (got.day_out !== want.day_out)
            report_mismatch("day_out", 32'(got.day_out), 32'(want.day_out));
        if (got.year_out !== want.year_out)
            report_mismatch("year_out", 32'(got.year_out), 32'(want.year_out));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
        result_count++;
    endtask

    // result side: check each accepted result, then pick the next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready) check_result(m_data);
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // reset date seen through a zero-day add and one increment
    task automatic test_reset_state();
        send_request(add_request(16'd0));
        send_request(noise_request(OP_INC));
    endtask

    // set field checks in order, including partly applied rejects
    task automatic test_set_checks();
        send_request(set_request(4'd0, 5'd1, 12'd2000));
        send_request(set_request(4'd15, 5'd31, 12'd4095));
        send_request(set_request(4'd5, 5'd10, 12'd1899));
        send_request(set_request(4'd6, 5'd10, 12'd2101));
        send_request(set_request(4'd7, 5'd0, 12'd2000));
        send_request(set_request(4'd4, 5'd31, 12'd2001));
        send_request(set_request(4'd2, 5'd29, 12'd1900));
        send_request(set_request(4'd2, 5'd29, 12'd2100));
        send_request(set_request(4'd2, 5'd29, 12'd2000));
        send_request(set_request(4'd12, 5'd31, 12'd2100));
        send_request(set_request(4'd0, 5'd0, 12'd0));
    endtask

    // month end in a leap year and year end
    task automatic test_rollover();
        send_request(set_request(4'd2, 5'd28, 12'd2004));
        send_request(noise_request(OP_INC));
        send_request(noise_request(OP_INC));
        send_request(set_request(4'd12, 5'd31, 12'd1999));
        send_request(noise_request(OP_INC));
    endtask

    // day left past the month end by minus-four or by a rejected set
    task automatic test_day_past_end();
        send_request(set_request(4'd2, 5'd29, 12'd1904));
        send_request(noise_request(OP_SUB));
        send_request(noise_request(OP_INC));
        send_request(set_request(4'd1, 5'd31, 12'd2001));
        send_request(set_request(4'd2, 5'd5, 12'd1800));
        send_request(noise_request(OP_INC));
    endtask

    task automatic test_add_days();
        send_request(add_request(16'd1));
        send_request(add_request(16'd365));
        send_request(add_request(16'hffff));
        send_request(add_request(16'd0));
    endtask

    // walk the year down past zero to 4095, then increment across the wrap
    task automatic test_year_wrap();
        send_request(set_request(4'd12, 5'd31, 12'd1903));
        repeat (476) send_request(noise_request(OP_SUB));
        send_request(noise_request(OP_INC));
        send_request(add_request(16'd59));
        send_request(noise_request(OP_SUB));
        send_request(noise_request(OP_INC));
        send_request(set_request(4'd3, 5'd15, 12'd2050));
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (40) send_request(random_request());
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (RANDOM_ITEMS) send_request(random_request());
    endtask

    initial begin : run_regression
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_set_checks();
        test_rollover();
        test_day_past_end();
        test_add_days();
        test_year_wrap();
        test_back_to_back();
        test_random_mix();
        s_valid <= 1'b0;
        while (expected_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests and %0d results in %0d cycles",
                 request_count, result_count, cycle_count);
        $display("%0d sets rejected, %0d days added, year wrapped through zero",
                 rejected_sets, days_added);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // cycle limit on the whole run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, expected_dates.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
